// ----- hw/rtl/kic_pkg.sv -----
// shared types, widths and keypad codes for the keypad integer calculator
// no dependencies
package kic_pkg;

	localparam int MAX_DIGITS = 7;
	localparam int KEY_W = 5;
	localparam int OPERAND_W = 24;
	localparam int ANSWER_W = 48;
	localparam int LEFTOVER_W = 24;
	localparam int DIGIT_W = 4;
	localparam int CNT_W = $clog2(OPERAND_W);

	// raw keypad codes
	localparam logic [KEY_W-1:0] KC_D1 = 5'd1;
	localparam logic [KEY_W-1:0] KC_D2 = 5'd2;
	localparam logic [KEY_W-1:0] KC_D3 = 5'd3;
	localparam logic [KEY_W-1:0] KC_PLUS = 5'd4;
	localparam logic [KEY_W-1:0] KC_D4 = 5'd5;
	localparam logic [KEY_W-1:0] KC_D5 = 5'd6;
	localparam logic [KEY_W-1:0] KC_D6 = 5'd7;
	localparam logic [KEY_W-1:0] KC_MINUS = 5'd8;
	localparam logic [KEY_W-1:0] KC_D7 = 5'd9;
	localparam logic [KEY_W-1:0] KC_D8 = 5'd10;
	localparam logic [KEY_W-1:0] KC_D9 = 5'd11;
	localparam logic [KEY_W-1:0] KC_TIMES = 5'd12;
	localparam logic [KEY_W-1:0] KC_CLEAR = 5'd13;
	localparam logic [KEY_W-1:0] KC_D0 = 5'd14;
	localparam logic [KEY_W-1:0] KC_EQUALS = 5'd15;
	localparam logic [KEY_W-1:0] KC_DIVIDE = 5'd16;

	// pending operator flag positions
	localparam int OPF_ADD = 0;
	localparam int OPF_SUB = 1;
	localparam int OPF_MUL = 2;
	localparam int OPF_DIV = 3;

	typedef enum logic [2:0] {
		KEY_NONE,
		KEY_DIGIT,
		KEY_ADD,
		KEY_SUB,
		KEY_MUL,
		KEY_DIV,
		KEY_CLEAR,
		KEY_EQUALS
	} key_kind_t;

	typedef struct packed {
		key_kind_t kind;
		logic [DIGIT_W-1:0] digit;
	} key_t;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_DIV
	} alu_op_t;

	typedef struct packed {
		logic start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic done;
	} alu_rsp_t;

	// smallest value that already holds MAX_DIGITS significant digits
	function automatic logic [63:0] digit_limit();
		logic [63:0] v;
		v = 64'd1;
		for (int i = 1; i < MAX_DIGITS; i++) begin
			v = v * 64'd10;
		end
		return v;
	endfunction

	localparam logic [63:0] DIGIT_LIMIT = digit_limit();

	function automatic key_t key_decode(input logic [KEY_W-1:0] code);
		key_t k;
		k.kind = KEY_DIGIT;
		k.digit = '0;
		unique case (code)
			KC_D0: k.digit = 4'd0;
			KC_D1: k.digit = 4'd1;
			KC_D2: k.digit = 4'd2;
			KC_D3: k.digit = 4'd3;
			KC_D4: k.digit = 4'd4;
			KC_D5: k.digit = 4'd5;
			KC_D6: k.digit = 4'd6;
			KC_D7: k.digit = 4'd7;
			KC_D8: k.digit = 4'd8;
			KC_D9: k.digit = 4'd9;
			KC_PLUS: k.kind = KEY_ADD;
			KC_MINUS: k.kind = KEY_SUB;
			KC_TIMES: k.kind = KEY_MUL;
			KC_DIVIDE: k.kind = KEY_DIV;
			KC_CLEAR: k.kind = KEY_CLEAR;
			KC_EQUALS: k.kind = KEY_EQUALS;
			default: k.kind = KEY_NONE;
		endcase
		return k;
	endfunction

	// operand * 10 + digit; an operand that already holds MAX_DIGITS digits is kept unchanged
	function automatic logic [OPERAND_W-1:0] append_digit(
		input logic [OPERAND_W-1:0] operand,
		input logic [DIGIT_W-1:0] digit
	);
		logic [OPERAND_W+3:0] ext;
		logic [OPERAND_W+3:0] sum;
		ext = {4'b0, operand};
		sum = (ext << 3) + (ext << 1) + {{OPERAND_W{1'b0}}, digit};
		if ({{(64-OPERAND_W){1'b0}}, operand} >= DIGIT_LIMIT) begin
			return operand;
		end
		return sum[OPERAND_W-1:0];
	endfunction

endpackage

// ----- hw/rtl/keypad_integer_calculator.sv -----
// keypad integer calculator: key decode, operand entry and result sequencing
// depends on kic_pkg and kic_alu
//
// usage:
//   input channel key_code with in_valid/in_ready carries raw 4x4 keypad codes.
//   digit, operator, clear and unmapped keys make no result;
//   digit and operator keys are taken even while an earlier result waits.
//   equals makes one result on the output channel (answer, leftover,
//   divide_by_zero with out_valid/out_ready) and clears all operand state.
//   equals with no operator or divide by zero bypasses the alu; add and
//   subtract use the shared iterative adder directly, and multiply and
//   divide run its 24 steps. in_ready stays low from equals until the
//   result sits in the output register.
//   a stalled receiver holds the result in the output register; the next
//   equals then waits until that result is taken.
//   reset clears both operands and all pending operator flags.
module keypad_integer_calculator import kic_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [KEY_W-1:0]       key_code,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [ANSWER_W-1:0] answer,
	output logic [LEFTOVER_W-1:0]  leftover,
	output logic                   divide_by_zero
);

	typedef enum logic [1:0] {S_IDLE, S_CALC, S_WAIT} state_t;

	state_t state_q;
	logic [OPERAND_W-1:0] first_q;
	logic [OPERAND_W-1:0] second_q;
	logic [3:0] pend_q;
	logic zero_q;
	logic dz_q;
	logic out_valid_q;
	logic [ANSWER_W-1:0] answer_q;
	logic [LEFTOVER_W-1:0] leftover_q;
	logic dz_out_q;

	key_t key;
	logic accept;
	logic slot_free;
	alu_req_t alu_req;
	alu_rsp_t alu_rsp;
	logic [ANSWER_W-1:0] alu_answer;
	logic [LEFTOVER_W-1:0] alu_leftover;
	logic no_op;
	logic div_zero;

	assign key = key_decode(key_code);
	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	assign no_op = (pend_q == 4'b0);
	assign div_zero = pend_q[OPF_DIV] && (second_q == '0);

	// operator priority on equals: divide, multiply, subtract, add
	always_comb begin
		alu_req.start = accept && (key.kind == KEY_EQUALS) && !no_op && !div_zero;
		alu_req.op = ALU_ADD;
		priority if (pend_q[OPF_DIV]) alu_req.op = ALU_DIV;
		else if (pend_q[OPF_MUL]) alu_req.op = ALU_MUL;
		else if (pend_q[OPF_SUB]) alu_req.op = ALU_SUB;
		else alu_req.op = ALU_ADD;
	end

	kic_alu u_alu (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (alu_req),
		.a        (first_q),
		.b        (second_q),
		.rsp      (alu_rsp),
		.answer   (alu_answer),
		.leftover (alu_leftover)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			first_q <= '0;
			second_q <= '0;
			pend_q <= '0;
			zero_q <= 1'b0;
			dz_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (key.kind)
							KEY_DIGIT: begin
								if (pend_q != 4'b0) begin
									second_q <= append_digit(second_q, key.digit);
								end else begin
									first_q <= append_digit(first_q, key.digit);
								end
							end
							KEY_ADD: pend_q[OPF_ADD] <= 1'b1;
							KEY_SUB: pend_q[OPF_SUB] <= 1'b1;
							KEY_MUL: pend_q[OPF_MUL] <= 1'b1;
							KEY_DIV: pend_q[OPF_DIV] <= 1'b1;
							KEY_CLEAR: begin
								first_q <= '0;
								second_q <= '0;
								pend_q <= '0;
							end
							KEY_EQUALS: begin
								// alu samples the operands at this edge
								first_q <= '0;
								second_q <= '0;
								pend_q <= '0;
								zero_q <= no_op || div_zero;
								dz_q <= div_zero;
								state_q <= (no_op || div_zero) ? S_WAIT : S_CALC;
							end
							KEY_NONE: ;
						endcase
					end
				end
				S_CALC: begin
					if (alu_rsp.done) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						answer_q <= zero_q ? '0 : alu_answer;
						leftover_q <= zero_q ? '0 : alu_leftover;
						dz_out_q <= dz_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign answer = answer_q;
	assign leftover = leftover_q;
	assign divide_by_zero = dz_out_q;

endmodule

// ----- hw/rtl/kic_alu.sv -----
// iterative arithmetic unit: one 26-bit add/subtract reused for add, subtract,
// shift-add multiply and restoring divide; depends on kic_pkg
module kic_alu import kic_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  alu_req_t               req,
	input  logic [OPERAND_W-1:0]   a,
	input  logic [OPERAND_W-1:0]   b,
	output alu_rsp_t               rsp,
	output logic [ANSWER_W-1:0]    answer,
	output logic [LEFTOVER_W-1:0]  leftover
);

	typedef enum logic {A_IDLE, A_RUN} alu_state_t;

	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(OPERAND_W - 1);

	alu_state_t state_q;
	alu_op_t op_q;
	logic [CNT_W-1:0] cnt_q;
	logic [OPERAND_W-1:0] hi_q;
	logic [OPERAND_W-1:0] lo_q;
	logic [OPERAND_W-1:0] opnd_q;
	logic [ANSWER_W-1:0] ans_q;
	logic [LEFTOVER_W-1:0] rem_q;
	logic done_q;

	logic [OPERAND_W:0] ua;
	logic [OPERAND_W:0] ub;
	logic usub;
	logic [OPERAND_W+1:0] sum;
	logic [OPERAND_W-1:0] next_hi;
	logic [OPERAND_W-1:0] next_lo;
	logic qbit;

	// the one shared adder
	always_comb begin
		ua = {1'b0, lo_q};
		ub = {1'b0, opnd_q};
		usub = 1'b0;
		unique case (op_q)
			ALU_ADD: usub = 1'b0;
			ALU_SUB: usub = 1'b1;
			ALU_MUL: begin
				ua = {1'b0, hi_q};
				ub = lo_q[0] ? {1'b0, opnd_q} : '0;
			end
			ALU_DIV: begin
				ua = {hi_q, lo_q[OPERAND_W-1]};
				usub = 1'b1;
			end
		endcase
		sum = {1'b0, ua} + (usub ? ~{1'b0, ub} : {1'b0, ub})
			+ {{(OPERAND_W+1){1'b0}}, usub};
	end

	always_comb begin
		qbit = ~sum[OPERAND_W+1];
		if (op_q == ALU_MUL) begin
			next_hi = sum[OPERAND_W:1];
			next_lo = {sum[0], lo_q[OPERAND_W-1:1]};
		end else begin
			next_hi = qbit ? sum[OPERAND_W-1:0] : ua[OPERAND_W-1:0];
			next_lo = {lo_q[OPERAND_W-2:0], qbit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			op_q <= ALU_ADD;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				A_IDLE: begin
					if (req.start) begin
						state_q <= A_RUN;
						op_q <= req.op;
						cnt_q <= '0;
						hi_q <= '0;
						// multiply: multiplier shifts in lo; divide: dividend shifts out of lo
						lo_q <= (req.op == ALU_MUL) ? b : a;
						opnd_q <= (req.op == ALU_MUL) ? a : b;
					end
				end
				A_RUN: begin
					unique case (op_q)
						ALU_ADD: begin
							ans_q <= {{(ANSWER_W-OPERAND_W-1){1'b0}}, sum[OPERAND_W:0]};
							rem_q <= '0;
							done_q <= 1'b1;
							state_q <= A_IDLE;
						end
						ALU_SUB: begin
							ans_q <= {{(ANSWER_W-OPERAND_W-2){sum[OPERAND_W+1]}}, sum};
							rem_q <= '0;
							done_q <= 1'b1;
							state_q <= A_IDLE;
						end
						ALU_MUL, ALU_DIV: begin
							hi_q <= next_hi;
							lo_q <= next_lo;
							cnt_q <= cnt_q + 1'b1;
							if (cnt_q == LAST_STEP) begin
								if (op_q == ALU_MUL) begin
									ans_q <= {next_hi, next_lo};
									rem_q <= '0;
								end else begin
									ans_q <= {{(ANSWER_W-OPERAND_W){1'b0}}, next_lo};
									rem_q <= next_hi;
								end
								done_q <= 1'b1;
								state_q <= A_IDLE;
							end
						end
					endcase
				end
			endcase
		end
	end

	assign rsp.done = done_q;
	assign answer = ans_q;
	assign leftover = rem_q;

endmodule
